>>> rtl/hcbd_pkg.sv
// Shared types and constants for the chunked HTTP body decoder.
package hcbd_pkg;

	// Parser phases.
	typedef enum logic [3:0] {
		PH_SIZE,
		PH_SIZE_TAIL,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_TRAILER,
		PH_FIXED,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Input operations.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Configuration register indexes.
	localparam logic REG_CHUNKED_MODE = 1'b0;
	localparam logic REG_BODY_LENGTH  = 1'b1;

	// Byte codes that the parser looks for.
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// One item handed from the input stage to the parser.
	typedef struct packed {
		logic       valid;
		logic       op;
		logic [7:0] data;
	} item_t;

	// One result handed from the parser to the output register.
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

>>> rtl/hcbd_parser.sv
// Decoder state registers and the per-byte next-state logic.
module hcbd_parser #(
	parameter int SIZE_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              chunked_mode,
	input  logic [31:0]       body_length,
	input  hcbd_pkg::item_t   item,
	output hcbd_pkg::result_t result
);

	localparam int DW = $clog2(SIZE_DIGITS + 1);

	hcbd_pkg::phase_t phase_q, phase_d;
	logic [31:0]      size_accum_q, size_accum_d;
	logic [DW-1:0]    digit_count_q, digit_count_d;
	logic [31:0]      bytes_left_q, bytes_left_d;
	logic             line_empty_q, line_empty_d;

	logic             is_hex;
	logic [3:0]       hex_val;
	logic             is_blank;
	logic             end_line;
	logic [31:0]      bytes_dec;

	// Hex digit decode of the incoming byte.
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (item.data >= "0" && item.data <= "9") begin
			hex_val = 4'(item.data - "0");
		end else if (item.data >= "a" && item.data <= "f") begin
			hex_val = 4'(item.data - "a" + 8'd10);
		end else if (item.data >= "A" && item.data <= "F") begin
			hex_val = 4'(item.data - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign is_blank = (item.data == hcbd_pkg::CH_SPACE) || (item.data == hcbd_pkg::CH_TAB) ||
		(item.data == hcbd_pkg::CH_CR);
	assign bytes_dec = bytes_left_q - 32'd1;

	// Next state and result for the item in the input stage.
	always_comb begin
		phase_d       = phase_q;
		size_accum_d  = size_accum_q;
		digit_count_d = digit_count_q;
		bytes_left_d  = bytes_left_q;
		line_empty_d  = line_empty_q;
		result        = '0;
		end_line      = 1'b0;

		if (item.valid) begin
			if (item.op == hcbd_pkg::OP_RESTART) begin
				phase_d       = hcbd_pkg::PH_SIZE;
				size_accum_d  = '0;
				digit_count_d = '0;
				bytes_left_d  = '0;
				line_empty_d  = 1'b1;
				if (!chunked_mode) begin
					bytes_left_d = body_length;
					if (body_length == 32'd0) begin
						phase_d      = hcbd_pkg::PH_DONE;
						result.valid = 1'b1;
						result.kind  = hcbd_pkg::KIND_END;
						result.last  = 1'b1;
					end else begin
						phase_d = hcbd_pkg::PH_FIXED;
					end
				end
			end else begin
				unique case (phase_q) inside
					hcbd_pkg::PH_SIZE: begin
						if (is_hex) begin
							if (digit_count_q >= DW'(SIZE_DIGITS)) begin
								phase_d      = hcbd_pkg::PH_ERROR;
								result.valid = 1'b1;
								result.kind  = hcbd_pkg::KIND_ERR;
								result.last  = 1'b1;
							end else begin
								size_accum_d  = {size_accum_q[27:0], hex_val};
								digit_count_d = digit_count_q + DW'(1);
								line_empty_d  = 1'b0;
							end
						end else if (item.data == hcbd_pkg::CH_LF) begin
							end_line = 1'b1;
						end else if (is_blank && digit_count_q != '0) begin
							phase_d = hcbd_pkg::PH_SIZE_TAIL;
						end else begin
							phase_d      = hcbd_pkg::PH_ERROR;
							result.valid = 1'b1;
							result.kind  = hcbd_pkg::KIND_ERR;
							result.last  = 1'b1;
						end
					end
					hcbd_pkg::PH_SIZE_TAIL: begin
						if (item.data == hcbd_pkg::CH_LF) begin
							end_line = 1'b1;
						end else if (!is_blank) begin
							phase_d      = hcbd_pkg::PH_ERROR;
							result.valid = 1'b1;
							result.kind  = hcbd_pkg::KIND_ERR;
							result.last  = 1'b1;
						end
					end
					hcbd_pkg::PH_DATA: begin
						bytes_left_d = bytes_dec;
						if (bytes_dec == 32'd0) begin
							phase_d = hcbd_pkg::PH_DATA_CR;
						end
						result.valid = 1'b1;
						result.kind  = hcbd_pkg::KIND_BYTE;
						result.data  = item.data;
					end
					hcbd_pkg::PH_DATA_CR, hcbd_pkg::PH_DATA_LF: begin
						if (item.data == hcbd_pkg::CH_CR && phase_q == hcbd_pkg::PH_DATA_CR) begin
							phase_d = hcbd_pkg::PH_DATA_LF;
						end else if (item.data == hcbd_pkg::CH_LF) begin
							phase_d       = hcbd_pkg::PH_SIZE;
							size_accum_d  = '0;
							digit_count_d = '0;
							bytes_left_d  = '0;
							line_empty_d  = 1'b1;
						end else begin
							phase_d      = hcbd_pkg::PH_ERROR;
							result.valid = 1'b1;
							result.kind  = hcbd_pkg::KIND_ERR;
							result.last  = 1'b1;
						end
					end
					hcbd_pkg::PH_TRAILER: begin
						if (item.data == hcbd_pkg::CH_LF) begin
							if (line_empty_q) begin
								phase_d      = hcbd_pkg::PH_DONE;
								result.valid = 1'b1;
								result.kind  = hcbd_pkg::KIND_END;
								result.last  = 1'b1;
							end else begin
								line_empty_d = 1'b1;
							end
						end else if (item.data != hcbd_pkg::CH_CR) begin
							line_empty_d = 1'b0;
						end
					end
					hcbd_pkg::PH_FIXED: begin
						bytes_left_d = bytes_dec;
						result.valid = 1'b1;
						result.kind  = hcbd_pkg::KIND_BYTE;
						result.data  = item.data;
						if (bytes_dec == 32'd0) begin
							phase_d     = hcbd_pkg::PH_DONE;
							result.last = 1'b1;
						end
					end
					default: begin
					end
				endcase

				// End of a size line: a zero size opens the trailer section.
				if (end_line) begin
					if (digit_count_q == '0) begin
						phase_d      = hcbd_pkg::PH_ERROR;
						result.valid = 1'b1;
						result.kind  = hcbd_pkg::KIND_ERR;
						result.last  = 1'b1;
					end else if (size_accum_q == 32'd0) begin
						phase_d      = hcbd_pkg::PH_TRAILER;
						line_empty_d = 1'b1;
					end else begin
						phase_d      = hcbd_pkg::PH_DATA;
						bytes_left_d = size_accum_q;
					end
				end
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hcbd_pkg::PH_SIZE;
			size_accum_q  <= '0;
			digit_count_q <= '0;
			bytes_left_q  <= '0;
			line_empty_q  <= 1'b1;
		end else begin
			phase_q       <= phase_d;
			size_accum_q  <= size_accum_d;
			digit_count_q <= digit_count_d;
			bytes_left_q  <= bytes_left_d;
			line_empty_q  <= line_empty_d;
		end
	end

endmodule

>>> rtl/http_chunked_body_decoder.sv
// Top level of the chunked HTTP body decoder: input stage, parser, output register.
//
// The decoder takes one body byte or restart per cycle and gives at most one
// result per item: an item waits in the input register, then the parser
// updates its state and loads the output register. One item per cycle is
// sustained as long as the output side takes results; a result waiting on the
// output side still lets one more item into the input register. In chunked
// mode it strips size lines, chunk delimiters and trailer, ending with an end
// marker or an error result; in fixed mode it passes body_length bytes, marks
// the last with tlast, and gives only an end marker for a zero body_length.
// Configuration (chunked_mode, body_length) is sampled on a restart.
module http_chunked_body_decoder #(
	parameter int SIZE_DIGITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] op
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	logic              chunked_mode_q;
	logic [31:0]       body_length_q;
	logic              valid_s1;
	logic              op_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_free;
	logic              advance;
	hcbd_pkg::item_t   item;
	hcbd_pkg::result_t result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b1;
			body_length_q  <= '0;
		end else if (wr_en) begin
			if (wr_index == hcbd_pkg::REG_CHUNKED_MODE) begin
				chunked_mode_q <= wr_data[0];
			end else if (wr_index == hcbd_pkg::REG_BODY_LENGTH) begin
				body_length_q <= wr_data;
			end
		end
	end

	// The item in the input stage moves on when the output register is free.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign item.valid = advance;
	assign item.op    = op_s1;
	assign item.data  = byte_s1;

	hcbd_parser #(
		.SIZE_DIGITS(SIZE_DIGITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.chunked_mode (chunked_mode_q),
		.body_length  (body_length_q),
		.item         (item),
		.result       (result)
	);

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_kind_q <= result.kind;
			out_byte_q <= result.data;
			out_last_q <= result.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
